// ----- rtl/lcpt_pkg.sv -----
// ----------------------------------------------------------------------------
// lcpt_pkg
// Shared types and constants for the smoothed conditional probability table.
// ----------------------------------------------------------------------------
package lcpt_pkg;

    localparam int MAX_SOURCES_DEF = 16;
    localparam int MAX_TARGETS_DEF = 16;
    localparam int TOTAL_BITS_DEF  = 24;

    localparam int KIND_W  = 2;
    localparam int IDX_W   = 4;
    localparam int COUNT_W = 16;
    localparam int VALUE_W = 22;
    localparam int SIZE_W  = 5;
    localparam int DIM_W   = 9;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam int QUEUE_DEPTH = 2;

    localparam int Q_STEPS   = 17;
    localparam int LOG_FRAC  = 20;
    localparam int MANT_W    = 31;
    localparam int LN_SHIFT  = 36;
    localparam int LOG_FLOOR = 2097152;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    localparam logic [1:0] REG_SOURCE_SIZE = 2'd0;
    localparam logic [1:0] REG_TARGET_SIZE = 2'd1;
    localparam logic [1:0] REG_TARGET_DIR  = 2'd2;
    localparam logic [1:0] REG_LOG_OUTPUT  = 2'd3;

    localparam logic [SIZE_W-1:0] SOURCE_SIZE_RST = 5'd1;
    localparam logic [SIZE_W-1:0] TARGET_SIZE_RST = 5'd1;
    localparam logic              TARGET_DIR_RST  = 1'b1;
    localparam logic              LOG_OUTPUT_RST  = 1'b0;

    typedef struct packed {
        logic [SIZE_W-1:0] source_size;
        logic [SIZE_W-1:0] target_size;
        logic              target_direction;
        logic              log_output;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [IDX_W-1:0]   src;
        logic [IDX_W-1:0]   tgt;
        logic [COUNT_W-1:0] cnt;
        logic [DIM_W-1:0]   size;
        logic               err;
    } item_t;

endpackage

// ----- rtl/lcpt_ram.sv -----
// ----------------------------------------------------------------------------
// lcpt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lcpt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/lcpt_cfg.sv -----
// ----------------------------------------------------------------------------
// lcpt_cfg
// APB register file: table sizes, conditioning direction and output format.
// ----------------------------------------------------------------------------
module lcpt_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lcpt_pkg::ADDR_W-1:0] paddr,
    input  logic [lcpt_pkg::DATA_W-1:0] pwdata,
    output logic [lcpt_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output lcpt_pkg::cfg_t              cfg
);

    lcpt_pkg::cfg_t cfg_reg;
    logic           wr_en;

    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_size      <= lcpt_pkg::SOURCE_SIZE_RST;
            cfg_reg.target_size      <= lcpt_pkg::TARGET_SIZE_RST;
            cfg_reg.target_direction <= lcpt_pkg::TARGET_DIR_RST;
            cfg_reg.log_output       <= lcpt_pkg::LOG_OUTPUT_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                lcpt_pkg::REG_SOURCE_SIZE:
                    cfg_reg.source_size <= pwdata[lcpt_pkg::SIZE_W-1:0];
                lcpt_pkg::REG_TARGET_SIZE:
                    cfg_reg.target_size <= pwdata[lcpt_pkg::SIZE_W-1:0];
                lcpt_pkg::REG_TARGET_DIR:
                    cfg_reg.target_direction <= pwdata[0];
                lcpt_pkg::REG_LOG_OUTPUT:
                    cfg_reg.log_output <= pwdata[0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            lcpt_pkg::REG_SOURCE_SIZE:
                prdata = lcpt_pkg::DATA_W'(cfg_reg.source_size);
            lcpt_pkg::REG_TARGET_SIZE:
                prdata = lcpt_pkg::DATA_W'(cfg_reg.target_size);
            lcpt_pkg::REG_TARGET_DIR:
                prdata = lcpt_pkg::DATA_W'(cfg_reg.target_direction);
            lcpt_pkg::REG_LOG_OUTPUT:
                prdata = lcpt_pkg::DATA_W'(cfg_reg.log_output);
            default:
                prdata = '0;
        endcase
    end

endmodule

// ----- rtl/lcpt_front.sv -----
// ----------------------------------------------------------------------------
// lcpt_front
// Accepts input beats, checks indexes against the sizes in use and forwards
// clear items, in-range load items and queries to the work queue.
// ----------------------------------------------------------------------------
module lcpt_front #(
    parameter int MAX_SOURCES = lcpt_pkg::MAX_SOURCES_DEF,
    parameter int MAX_TARGETS = lcpt_pkg::MAX_TARGETS_DEF
) (
    input  logic                         start,
    output logic                         busy,
    input  logic [lcpt_pkg::KIND_W-1:0]  kind,
    input  logic [lcpt_pkg::IDX_W-1:0]   source_index,
    input  logic [lcpt_pkg::IDX_W-1:0]   target_index,
    input  logic [lcpt_pkg::COUNT_W-1:0] count,
    input  lcpt_pkg::cfg_t               cfg,
    input  logic                         q_full,
    input  logic                         init_busy,
    output logic                         push,
    output lcpt_pkg::item_t              item
);

    localparam int DW = lcpt_pkg::DIM_W;

    logic [DW-1:0] ns;
    logic [DW-1:0] nt;
    logic          in_range;
    logic          keep;

    always_comb
    begin
        ns = (DW'(cfg.source_size) > DW'(MAX_SOURCES)) ? DW'(MAX_SOURCES)
                                                       : DW'(cfg.source_size);
        nt = (DW'(cfg.target_size) > DW'(MAX_TARGETS)) ? DW'(MAX_TARGETS)
                                                       : DW'(cfg.target_size);
        in_range = (DW'(source_index) < ns) && (DW'(target_index) < nt);
        case (kind)
            lcpt_pkg::KIND_CLEAR: keep = 1'b1;
            lcpt_pkg::KIND_LOAD:  keep = in_range;
            lcpt_pkg::KIND_QUERY: keep = 1'b1;
            default:              keep = 1'b0;
        endcase
    end

    assign busy = q_full || init_busy;
    assign push = start && !busy && keep;

    always_comb
    begin
        item.kind = kind;
        item.src  = source_index;
        item.tgt  = target_index;
        item.cnt  = count;
        item.size = cfg.target_direction ? nt : ns;
        item.err  = !in_range;
    end

endmodule

// ----- rtl/lcpt_queue.sv -----
// ----------------------------------------------------------------------------
// lcpt_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module lcpt_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lcpt_pkg::item_t push_item,
    input  logic            pop,
    output lcpt_pkg::item_t head,
    output logic            empty,
    output logic            full
);

    localparam int DEPTH = lcpt_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    lcpt_pkg::item_t entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   fill_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_next;

    assign empty = (fill_reg == '0);
    assign full  = (fill_reg == CW'(DEPTH));
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - CW'(1);
            end
        end
    end

endmodule

// ----- rtl/lcpt_back.sv -----
// ----------------------------------------------------------------------------
// lcpt_back
// Executes queued items: clearing sweep, saturating loads, and queries through
// a shift-add multiplier, a restoring divider and a squaring log2 unit.
// ----------------------------------------------------------------------------
module lcpt_back #(
    parameter int MAX_SOURCES = lcpt_pkg::MAX_SOURCES_DEF,
    parameter int MAX_TARGETS = lcpt_pkg::MAX_TARGETS_DEF,
    parameter int TOTAL_BITS  = lcpt_pkg::TOTAL_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lcpt_pkg::cfg_t                      cfg,
    input  lcpt_pkg::item_t                     head,
    input  logic                                empty,
    output logic                                pop,
    output logic                                init_busy,
    output logic                                done,
    output logic signed [lcpt_pkg::VALUE_W-1:0] value,
    output logic                                index_error
);

    localparam int TB    = TOTAL_BITS;
    localparam int CELLS = MAX_SOURCES * MAX_TARGETS;
    localparam int CAW   = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int RAW   = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int TAW   = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int N1W   = TB + 1;
    localparam int W     = 2 * TB + 1;
    localparam int EW    = $clog2(W);
    localparam int LW    = EW + lcpt_pkg::LOG_FRAC;
    localparam int STW   = $clog2(W + 1);
    localparam int MW    = lcpt_pkg::MANT_W;
    localparam int PW2   = LW + 32;
    localparam int GW    = PW2 + 1 - lcpt_pkg::LN_SHIFT;
    localparam int QW    = lcpt_pkg::Q_STEPS + 1;
    localparam int VW    = lcpt_pkg::VALUE_W;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_DIV,
        ST_ROUND,
        ST_NORM,
        ST_SQR,
        ST_LNMUL,
        ST_LNFIN
    } state_t;

    state_t          state_reg;
    logic            init_reg;
    logic [CAW-1:0]  swp_reg;
    lcpt_pkg::item_t cur_reg;
    logic [TB-1:0]   grand_reg;
    logic [W-1:0]    acc_a_reg;
    logic [W-1:0]    acc_b_reg;
    logic [W-1:0]    mcand_a_reg;
    logic [W-1:0]    mcand_b_reg;
    logic [N1W-1:0]  mplier_reg;
    logic [STW-1:0]  step_reg;
    logic [W-1:0]    den_reg;
    logic [W:0]      rem_reg;
    logic [QW-1:0]   quo_reg;
    logic [W-1:0]    nx_reg;
    logic [EW-1:0]   sh_reg;
    logic [MW-1:0]   m_reg;
    logic [LW-1:0]   l_reg;
    logic [LW-1:0]   ln_reg;
    logic            second_reg;
    logic [PW2-1:0]  lnp_reg;
    logic            done_reg;
    logic [VW-1:0]   value_reg;
    logic            err_reg;

    logic            cell_we;
    logic            row_we;
    logic            col_we;
    logic [CAW-1:0]  cell_waddr;
    logic [RAW-1:0]  row_waddr;
    logic [TAW-1:0]  col_waddr;
    logic [TB-1:0]   cell_wdata;
    logic [TB-1:0]   row_wdata;
    logic [TB-1:0]   col_wdata;
    logic [CAW-1:0]  cell_raddr;
    logic [TB-1:0]   cell_rd;
    logic [TB-1:0]   row_rd;
    logic [TB-1:0]   col_rd;

    logic [TB:0]     cell_sum;
    logic [TB:0]     row_sum;
    logic [TB:0]     col_sum;
    logic [TB:0]     grand_sum;
    logic [TB-1:0]   cell_sat;
    logic [TB-1:0]   row_sat;
    logic [TB-1:0]   col_sat;
    logic [TB-1:0]   grand_sat;
    logic            is_load;

    logic [W-1:0]    acc_a_next;
    logic [W-1:0]    acc_b_next;
    logic [W-1:0]    num_val;
    logic [W-1:0]    den_val;
    logic [W:0]      div_try;
    logic            div_ge;
    logic [W+1:0]    rem_dbl;
    logic [2*MW-1:0] sq;
    logic [MW:0]     sq_top;
    logic [MW-1:0]   m_next;
    logic [LW-1:0]   l_next;
    logic [LW-1:0]   l_norm;
    logic [LW-1:0]   diff;
    logic [PW2:0]    ln_rnd;
    logic [GW-1:0]   mag;
    logic [GW-1:0]   mag_sat;

    assign init_busy   = init_reg;
    assign done        = done_reg;
    assign value       = value_reg;
    assign index_error = err_reg;
    assign pop         = (state_reg == ST_IDLE) && !empty;
    assign is_load     = (cur_reg.kind == lcpt_pkg::KIND_LOAD);

    assign cell_raddr = CAW'(32'(head.src) * MAX_TARGETS + 32'(head.tgt));

    always_comb
    begin
        cell_sum  = {1'b0, cell_rd} + (TB + 1)'(cur_reg.cnt);
        row_sum   = {1'b0, row_rd} + (TB + 1)'(cur_reg.cnt);
        col_sum   = {1'b0, col_rd} + (TB + 1)'(cur_reg.cnt);
        grand_sum = {1'b0, grand_reg} + (TB + 1)'(cur_reg.cnt);
        cell_sat  = cell_sum[TB] ? '1 : cell_sum[TB-1:0];
        row_sat   = row_sum[TB] ? '1 : row_sum[TB-1:0];
        col_sat   = col_sum[TB] ? '1 : col_sum[TB-1:0];
        grand_sat = grand_sum[TB] ? '1 : grand_sum[TB-1:0];
    end

    always_comb
    begin
        cell_we    = 1'b0;
        row_we     = 1'b0;
        col_we     = 1'b0;
        cell_waddr = CAW'(32'(cur_reg.src) * MAX_TARGETS + 32'(cur_reg.tgt));
        row_waddr  = RAW'(cur_reg.src);
        col_waddr  = TAW'(cur_reg.tgt);
        cell_wdata = cell_sat;
        row_wdata  = row_sat;
        col_wdata  = col_sat;
        if (state_reg == ST_SWEEP)
        begin
            cell_we    = 1'b1;
            row_we     = 32'(swp_reg) < MAX_SOURCES;
            col_we     = 32'(swp_reg) < MAX_TARGETS;
            cell_waddr = swp_reg;
            row_waddr  = RAW'(swp_reg);
            col_waddr  = TAW'(swp_reg);
            cell_wdata = '0;
            row_wdata  = '0;
            col_wdata  = '0;
        end
        else if (state_reg == ST_READ && is_load)
        begin
            cell_we = 1'b1;
            row_we  = 1'b1;
            col_we  = 1'b1;
        end
    end

    lcpt_ram #(.WIDTH(TB), .DEPTH(CELLS)) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_rd)
    );

    lcpt_ram #(.WIDTH(TB), .DEPTH(MAX_SOURCES)) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (RAW'(head.src)),
        .rdata (row_rd)
    );

    lcpt_ram #(.WIDTH(TB), .DEPTH(MAX_TARGETS)) u_col_ram (
        .clk   (clk),
        .we    (col_we),
        .waddr (col_waddr),
        .wdata (col_wdata),
        .raddr (TAW'(head.tgt)),
        .rdata (col_rd)
    );

    // shift-add multiplier, restoring divider and log2 datapath
    always_comb
    begin
        acc_a_next = mplier_reg[0] ? acc_a_reg + mcand_a_reg : acc_a_reg;
        acc_b_next = mplier_reg[0] ? acc_b_reg + mcand_b_reg : acc_b_reg;
        num_val    = acc_a_next + W'(1);
        den_val    = acc_b_next + W'(cur_reg.size);

        div_try = (step_reg == '0) ? rem_reg : {rem_reg[W-1:0], 1'b0};
        div_ge  = div_try >= {1'b0, den_reg};
        rem_dbl = {rem_reg, 1'b0};

        l_norm = LW'(EW'(W - 1) - sh_reg) << lcpt_pkg::LOG_FRAC;

        sq     = (2 * MW)'(m_reg) * (2 * MW)'(m_reg);
        sq_top = sq[2*MW-1 -: (MW + 1)];
        if (sq_top[MW])
        begin
            m_next = sq_top[MW:1];
            l_next = l_reg | (LW'(1) << (STW'(lcpt_pkg::LOG_FRAC - 1) - step_reg));
        end
        else
        begin
            m_next = sq_top[MW-1:0];
            l_next = l_reg;
        end

        diff    = (l_reg > ln_reg) ? l_reg - ln_reg : '0;
        ln_rnd  = (PW2 + 1)'(lnp_reg) + ((PW2 + 1)'(1) << (lcpt_pkg::LN_SHIFT - 1));
        mag     = ln_rnd[PW2 -: GW];
        mag_sat = (mag > GW'(lcpt_pkg::LOG_FLOOR)) ? GW'(lcpt_pkg::LOG_FLOOR) : mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_SWEEP;
            init_reg   <= 1'b1;
            swp_reg    <= '0;
            grand_reg  <= '0;
            done_reg   <= 1'b0;
            err_reg    <= 1'b0;
            value_reg  <= '0;
            second_reg <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_SWEEP:
                begin
                    swp_reg <= swp_reg + CAW'(1);
                    if (swp_reg == CAW'(CELLS - 1))
                    begin
                        swp_reg   <= '0;
                        init_reg  <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (!empty)
                    begin
                        cur_reg <= head;
                        if (head.kind == lcpt_pkg::KIND_CLEAR)
                        begin
                            grand_reg <= '0;
                            swp_reg   <= '0;
                            state_reg <= ST_SWEEP;
                        end
                        else if (head.err)
                        begin
                            done_reg  <= 1'b1;
                            err_reg   <= 1'b1;
                            value_reg <= '0;
                        end
                        else
                        begin
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ:
                begin
                    if (is_load)
                    begin
                        grand_reg <= grand_sat;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        acc_a_reg   <= '0;
                        acc_b_reg   <= '0;
                        mcand_a_reg <= W'(cell_rd);
                        mcand_b_reg <= W'(cfg.target_direction ? row_rd : col_rd);
                        mplier_reg  <= N1W'(grand_reg) + N1W'(1);
                        step_reg    <= '0;
                        state_reg   <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    acc_a_reg   <= acc_a_next;
                    acc_b_reg   <= acc_b_next;
                    mcand_a_reg <= mcand_a_reg << 1;
                    mcand_b_reg <= mcand_b_reg << 1;
                    mplier_reg  <= mplier_reg >> 1;
                    step_reg    <= step_reg + STW'(1);
                    if (step_reg == STW'(N1W - 1))
                    begin
                        den_reg    <= den_val;
                        step_reg   <= '0;
                        rem_reg    <= {1'b0, num_val};
                        quo_reg    <= '0;
                        nx_reg     <= num_val;
                        sh_reg     <= '0;
                        second_reg <= 1'b0;
                        state_reg  <= cfg.log_output ? ST_NORM : ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    rem_reg  <= div_ge ? div_try - {1'b0, den_reg} : div_try;
                    quo_reg  <= {quo_reg[QW-2:0], div_ge};
                    step_reg <= step_reg + STW'(1);
                    if (step_reg == STW'(lcpt_pkg::Q_STEPS - 1))
                    begin
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    done_reg  <= 1'b1;
                    err_reg   <= 1'b0;
                    value_reg <= VW'(quo_reg)
                               + VW'(rem_dbl >= (W + 2)'(den_reg));
                    state_reg <= ST_IDLE;
                end
                ST_NORM:
                begin
                    if (nx_reg[W-1])
                    begin
                        m_reg     <= nx_reg[W-1 -: MW];
                        l_reg     <= l_norm;
                        step_reg  <= '0;
                        state_reg <= ST_SQR;
                    end
                    else if (nx_reg[W-1 -: 8] == '0)
                    begin
                        nx_reg <= nx_reg << 8;
                        sh_reg <= sh_reg + EW'(8);
                    end
                    else
                    begin
                        nx_reg <= nx_reg << 1;
                        sh_reg <= sh_reg + EW'(1);
                    end
                end
                ST_SQR:
                begin
                    m_reg    <= m_next;
                    l_reg    <= l_next;
                    step_reg <= step_reg + STW'(1);
                    if (step_reg == STW'(lcpt_pkg::LOG_FRAC - 1))
                    begin
                        step_reg <= '0;
                        if (!second_reg)
                        begin
                            ln_reg     <= l_next;
                            nx_reg     <= den_reg;
                            sh_reg     <= '0;
                            second_reg <= 1'b1;
                            state_reg  <= ST_NORM;
                        end
                        else
                        begin
                            state_reg <= ST_LNMUL;
                        end
                    end
                end
                ST_LNMUL:
                begin
                    lnp_reg   <= PW2'(diff) * PW2'(lcpt_pkg::LN2_Q32);
                    state_reg <= ST_LNFIN;
                end
                ST_LNFIN:
                begin
                    done_reg  <= 1'b1;
                    err_reg   <= 1'b0;
                    value_reg <= VW'(0) - VW'(mag_sat);
                    state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/laplace_conditional_prob_table_unit.sv -----
// ----------------------------------------------------------------------------
// laplace_conditional_prob_table_unit
// Contingency table of counts with Laplace-smoothed conditional probability
// queries, as probability in Q1.16 or natural log in signed Q5.16.
// ----------------------------------------------------------------------------
// Input channel: an item (kind, source_index, target_index, count) is taken at
// a clock edge with start high and busy low. Clear items, in-range load items
// and queries land in a two-entry queue; busy is high only while that queue is
// full or while the post-reset clearing pass runs.
// Result channel: each query gives one result on value and index_error, shown
// for exactly one cycle with done high. The receiver cannot stall the block.
// Work in the back end for each item, from queue pop to result:
//   load: a read and a saturating write-back; query out of range: an error result;
//   probability query: a shift-add multiplier over the TOTAL_BITS+1 bits of N+1,
//   then 17 restoring divide steps and a rounding;
//   log query: the same multiplier, then per operand a normalization and
//   20 squaring steps through one 31x31 multiplier, then a scaling multiply
//   and a rounding;
//   clear: one cell RAM entry per cycle.
// After reset the block clears its RAMs with busy high; configuration writes are
// taken meanwhile. Registers are on an APB port at byte addresses 0, 4, 8 and 12.
// ----------------------------------------------------------------------------
module laplace_conditional_prob_table_unit #(
    parameter int MAX_SOURCES = lcpt_pkg::MAX_SOURCES_DEF,
    parameter int MAX_TARGETS = lcpt_pkg::MAX_TARGETS_DEF,
    parameter int TOTAL_BITS  = lcpt_pkg::TOTAL_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [lcpt_pkg::KIND_W-1:0]         kind,
    input  logic [lcpt_pkg::IDX_W-1:0]          source_index,
    input  logic [lcpt_pkg::IDX_W-1:0]          target_index,
    input  logic [lcpt_pkg::COUNT_W-1:0]        count,
    output logic                                done,
    output logic signed [lcpt_pkg::VALUE_W-1:0] value,
    output logic                                index_error,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lcpt_pkg::ADDR_W-1:0]         paddr,
    input  logic [lcpt_pkg::DATA_W-1:0]         pwdata,
    output logic [lcpt_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    lcpt_pkg::cfg_t  cfg;
    lcpt_pkg::item_t push_item;
    lcpt_pkg::item_t head;
    logic            push;
    logic            pop;
    logic            q_empty;
    logic            q_full;
    logic            init_busy;

    lcpt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lcpt_front #(
        .MAX_SOURCES (MAX_SOURCES),
        .MAX_TARGETS (MAX_TARGETS)
    ) u_front (
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .source_index (source_index),
        .target_index (target_index),
        .count        (count),
        .cfg          (cfg),
        .q_full       (q_full),
        .init_busy    (init_busy),
        .push         (push),
        .item         (push_item)
    );

    lcpt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    lcpt_back #(
        .MAX_SOURCES (MAX_SOURCES),
        .MAX_TARGETS (MAX_TARGETS),
        .TOTAL_BITS  (TOTAL_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .head        (head),
        .empty       (q_empty),
        .pop         (pop),
        .init_busy   (init_busy),
        .done        (done),
        .value       (value),
        .index_error (index_error)
    );

endmodule

// ----- rtl/lcpt_checker.sv -----
// ----------------------------------------------------------------------------
// lcpt_checker
// Port-level checks on results, reset behavior and register readback.
// ----------------------------------------------------------------------------
module lcpt_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                busy,
    input logic                                done,
    input logic signed [lcpt_pkg::VALUE_W-1:0] value,
    input logic                                index_error,
    input logic                                psel,
    input logic                                pwrite,
    input logic [lcpt_pkg::ADDR_W-1:0]         paddr,
    input logic [lcpt_pkg::DATA_W-1:0]         prdata
);

    // out-of-range query beat carries a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && index_error |-> value == '0)
    else $error("index error with nonzero value");

    // a probability never exceeds one
    a_prob_max: assert property (@(posedge clk) disable iff (!rst_n)
        done && !index_error && !value[lcpt_pkg::VALUE_W-1] |-> value <= 65536)
    else $error("probability above one");

    // input held off while clearing after reset
    a_init_busy: assert property (@(posedge clk)
        $rose(rst_n) |-> busy)
    else $error("input open during reset clear");

    // size register reads back within its width
    a_size_rd: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite && (paddr[3:2] == lcpt_pkg::REG_SOURCE_SIZE)
        |-> prdata[lcpt_pkg::DATA_W-1:lcpt_pkg::SIZE_W] == '0)
    else $error("size readback too wide");

endmodule

bind laplace_conditional_prob_table_unit lcpt_checker u_lcpt_checker (.*);
